### rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP   = 2'd0,
    KIND_INSERT   = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_DUPLICATE = 3'd1,
    RC_NOT_FOUND = 3'd2,
    RC_NOT_AVAIL = 3'd3,
    RC_FULL      = 3'd4
  } result_code_t;

  localparam logic [1:0] STATUS_AVAILABLE = 2'd0;
  localparam logic [1:0] STATUS_DELETED   = 2'd1;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = KEY_W + STATUS_W;
  localparam int OUT_IDX_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_EXEC,
    ST_SHIFT_PRIME,
    ST_SHIFT,
    ST_PLACE,
    ST_RESULT
  } state_t;

endpackage

### rtl/core/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Ascending table of unique keys with a status each; lookup, insert with
// shift-up, and remove by marking deleted. Binary search over one RAM.
// ----------------------------------------------------------------------------
//  channel | dir | ports                                  | handshake
//  --------+-----+----------------------------------------+-----------------
//  in      | in  | in_kind, in_key, in_new_status         | in_valid/in_stall
//  out     | out | out_result_code, out_found, out_position,
//          |     | out_entry_status, out_table_full,
//          |     | out_entry_count                        | out_valid/out_stall
//
// One item at a time. Each binary search probe is a RAM read (SEARCH), then a
// compare (CMP). An insert then shifts the entries from the insertion point
// up by one, one entry per cycle through the single RAM port pair, and then
// places the new key. A result waits in the output register while the next
// item is taken. Synchronous reset clears the entry count; the RAM needs no
// clearing since only entries below the count are read.
module sorted_key_table #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key,
  input  logic [1:0]  in_new_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_code,
  output logic        out_found,
  output logic [6:0]  out_position,
  output logic [1:0]  out_entry_status,
  output logic        out_table_full,
  output logic [6:0]  out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  skt_pkg::state_t         state_r, state_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [1:0]              ns_r, ns_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;
  logic [CW-1:0]           hi_r, hi_nxt;
  logic [CW-1:0]           mid_r, mid_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    hit_r, hit_nxt;
  logic [1:0]              estat_r, estat_nxt;
  skt_pkg::result_code_t   code_r, code_nxt;

  logic                    out_valid_r, out_valid_nxt;
  skt_pkg::result_code_t   out_code_r, out_code_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [6:0]              out_pos_r, out_pos_nxt;
  logic [1:0]              out_estat_r, out_estat_nxt;
  logic                    out_full_r, out_full_nxt;
  logic [6:0]              out_cnt_r, out_cnt_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [skt_pkg::ENTRY_W-1:0] ram_wdata;
  logic [skt_pkg::ENTRY_W-1:0] ram_rdata;

  logic [CW-1:0]           mid_calc;
  logic [31:0]             rd_key;
  logic [1:0]              rd_status;

  assign mid_calc  = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key    = ram_rdata[skt_pkg::ENTRY_W-1:skt_pkg::STATUS_W];
  assign rd_status = ram_rdata[skt_pkg::STATUS_W-1:0];

  skt_ram #(
    .WIDTH (skt_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    ns_r        <= ns_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    hit_r       <= hit_nxt;
    estat_r     <= estat_nxt;
    code_r      <= code_nxt;
    out_code_r  <= out_code_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_estat_r <= out_estat_nxt;
    out_full_r  <= out_full_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    ns_nxt        = ns_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    hit_nxt       = hit_r;
    estat_nxt     = estat_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_estat_nxt = out_estat_r;
    out_full_nxt  = out_full_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = '0;
    ram_wdata     = '0;

    unique case (state_r)
      skt_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          ns_nxt    = in_new_status;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          hit_nxt   = 1'b0;
          estat_nxt = skt_pkg::STATUS_AVAILABLE;
          state_nxt = skt_pkg::ST_SEARCH;
        end
      end

      skt_pkg::ST_SEARCH: begin
        if (lo_r < hi_r) begin
          ram_raddr = mid_calc[AW-1:0];
          mid_nxt   = mid_calc;
          state_nxt = skt_pkg::ST_CMP;
        end else begin
          // miss: lo is the insertion point
          pos_nxt   = lo_r;
          state_nxt = skt_pkg::ST_EXEC;
        end
      end

      skt_pkg::ST_CMP: begin
        if (rd_key == key_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = mid_r;
          estat_nxt = rd_status;
          state_nxt = skt_pkg::ST_EXEC;
        end else if (rd_key < key_r) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = skt_pkg::ST_SEARCH;
        end else begin
          hi_nxt    = mid_r;
          state_nxt = skt_pkg::ST_SEARCH;
        end
      end

      skt_pkg::ST_EXEC: begin
        state_nxt = skt_pkg::ST_RESULT;
        case (kind_r)
          skt_pkg::KIND_INSERT: begin
            if (hit_r) begin
              code_nxt = skt_pkg::RC_DUPLICATE;
            end else if (count_r == CW'(DEPTH)) begin
              code_nxt = skt_pkg::RC_FULL;
            end else begin
              code_nxt  = skt_pkg::RC_OK;
              idx_nxt   = count_r;
              state_nxt = skt_pkg::ST_SHIFT_PRIME;
            end
          end
          skt_pkg::KIND_REMOVE: begin
            if (!hit_r) begin
              code_nxt = skt_pkg::RC_NOT_FOUND;
            end else if (estat_r != skt_pkg::STATUS_AVAILABLE) begin
              code_nxt = skt_pkg::RC_NOT_AVAIL;
            end else begin
              code_nxt  = skt_pkg::RC_OK;
              estat_nxt = skt_pkg::STATUS_DELETED;
              ram_we    = 1'b1;
              ram_waddr = pos_r[AW-1:0];
              ram_wdata = {key_r, skt_pkg::STATUS_DELETED};
            end
          end
          default: begin
            code_nxt = hit_r ? skt_pkg::RC_OK : skt_pkg::RC_NOT_FOUND;
          end
        endcase
      end

      skt_pkg::ST_SHIFT_PRIME: begin
        if (idx_r == pos_r) begin
          state_nxt = skt_pkg::ST_PLACE;
        end else begin
          ram_raddr = AW'(idx_r - CW'(1));
          state_nxt = skt_pkg::ST_SHIFT;
        end
      end

      skt_pkg::ST_SHIFT: begin
        // entry idx-1 arrives now; write it to idx and fetch the next one down
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - CW'(1);
        if (idx_r - CW'(1) == pos_r) begin
          state_nxt = skt_pkg::ST_PLACE;
        end else begin
          ram_raddr = AW'(idx_r - CW'(2));
        end
      end

      skt_pkg::ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = {key_r, ns_r};
        count_nxt = count_r + CW'(1);
        state_nxt = skt_pkg::ST_RESULT;
      end

      skt_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          out_found_nxt = hit_r;
          out_pos_nxt   = 7'(pos_r);
          out_estat_nxt = estat_r;
          out_full_nxt  = (count_r == CW'(DEPTH));
          out_cnt_nxt   = 7'(count_r);
          state_nxt     = skt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = skt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall         = (state_r != skt_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_code  = out_code_r;
  assign out_found        = out_found_r;
  assign out_position     = out_pos_r;
  assign out_entry_status = out_estat_r;
  assign out_table_full   = out_full_r;
  assign out_entry_count  = out_cnt_r;

  // table never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // count only ever grows by one, and only when an entry is placed
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) && ($past(state_r) == skt_pkg::ST_PLACE))
    else $error("entry count changed unexpectedly");

  // shift writes stay strictly above the insertion point
  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::ST_SHIFT) |-> (idx_r > pos_r) && (idx_r <= count_r))
    else $error("shift index out of range");

  // a duplicate refusal always reports the key as found
  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_code_r == skt_pkg::RC_DUPLICATE) |-> out_found_r)
    else $error("duplicate reported without hit");

endmodule

### tb/tb_sorted_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// Self-checking bench for the sorted key table. A clocked driver feeds
// lookups, inserts and removes from a queue of pending operations; a shadow
// copy of the sorted table predicts each result at the input transfer, and a
// clocked monitor checks every output transfer against the oldest prediction.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;

  localparam int TBL_DEPTH   = 64;
  localparam int RANDOM_OPS  = 930;
  localparam int DRAIN_CYC   = 200;
  localparam int HOLD_CYC    = 600;
  localparam int HOLD_AFTER  = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [1:0]  nstat;
  } table_op_t;

  typedef struct {
    skt_pkg::result_code_t code;
    logic                  found;
    logic [6:0]            position;
    logic [1:0]            entry_status;
    logic                  table_full;
    logic [6:0]            entry_count;
  } table_result_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind       = skt_pkg::KIND_LOOKUP;
  logic [31:0] in_key        = 32'd0;
  logic [1:0]  in_new_status = skt_pkg::STATUS_AVAILABLE;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [2:0]  out_result_code;
  logic        out_found;
  logic [6:0]  out_position;
  logic [1:0]  out_entry_status;
  logic        out_table_full;
  logic [6:0]  out_entry_count;

  sorted_key_table #(.DEPTH(TBL_DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_new_status    (in_new_status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_code  (out_result_code),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_entry_status (out_entry_status),
    .out_table_full   (out_table_full),
    .out_entry_count  (out_entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the table contents
  logic [31:0] shadow_keys [TBL_DEPTH];
  logic [1:0]  shadow_stat [TBL_DEPTH];
  int          shadow_count = 0;

  table_op_t     pending_ops[$];
  table_result_t awaited_results[$];
  logic [31:0]   key_pool[$];

  int          items_sent   = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          code_seen [5];
  int          max_entries  = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  int          hold_left    = 0;
  logic        hold_done    = 1'b0;
  logic        hold_active;
  logic [31:0] cyc          = 32'd0;
  logic        calm;

  assign hold_active = (hold_left != 0);
  // periodic windows with no random idling on either side
  assign calm = (cyc[10:9] == 2'b00);

  always @(posedge clk) cyc <= cyc + 32'd1;

  // Binary search plus table update; returns what the block should report.
  function automatic table_result_t table_step(input logic [1:0] kind,
                                               input logic [31:0] key,
                                               input logic [1:0] nstat);
    table_result_t r;
    int lo;
    int hi;
    int mid;
    int pos;
    int i;
    logic hit;
    lo  = 0;
    hi  = shadow_count;
    hit = 1'b0;
    pos = 0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] == key) begin
        hit = 1'b1;
        pos = mid;
      end else if (shadow_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (!hit) pos = lo;
    r.found        = hit;
    r.entry_status = hit ? shadow_stat[pos] : skt_pkg::STATUS_AVAILABLE;
    if (kind == skt_pkg::KIND_INSERT) begin
      if (hit) begin
        r.code = skt_pkg::RC_DUPLICATE;
      end else if (shadow_count >= TBL_DEPTH) begin
        r.code = skt_pkg::RC_FULL;
      end else begin
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_stat[i] = shadow_stat[i-1];
        end
        shadow_keys[pos] = key;
        shadow_stat[pos] = nstat;
        shadow_count++;
        r.code = skt_pkg::RC_OK;
      end
    end else if (kind == skt_pkg::KIND_REMOVE) begin
      if (!hit) begin
        r.code = skt_pkg::RC_NOT_FOUND;
      end else if (shadow_stat[pos] != skt_pkg::STATUS_AVAILABLE) begin
        r.code = skt_pkg::RC_NOT_AVAIL;
      end else begin
        shadow_stat[pos] = skt_pkg::STATUS_DELETED;
        r.entry_status   = skt_pkg::STATUS_DELETED;
        r.code           = skt_pkg::RC_OK;
      end
    end else begin
      // unused kind 3 behaves as a lookup
      r.code = hit ? skt_pkg::RC_OK : skt_pkg::RC_NOT_FOUND;
    end
    r.position    = pos[6:0];
    r.table_full  = (shadow_count == TBL_DEPTH);
    r.entry_count = shadow_count[6:0];
    return r;
  endfunction

  // idle run length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // keys biased toward ones already used, their neighbors and the extremes
  function automatic logic [31:0] pick_key();
    int r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if (key_pool.size() == 0 || r < 35) begin
      k = $urandom();
    end else if (r < 75) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (r < 90) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = ($urandom_range(0, 1) == 0) ? k + 32'd1 : k - 32'd1;
    end else begin
      case ($urandom_range(0, 3))
        0:       k = 32'h0000_0000;
        1:       k = 32'hFFFF_FFFF;
        2:       k = 32'h0000_0001;
        default: k = 32'hFFFF_FFFE;
      endcase
    end
    return k;
  endfunction

  task automatic push_op(input logic [1:0] kind, input logic [31:0] key,
                         input logic [1:0] nstat);
    table_op_t op;
    op.kind  = kind;
    op.key   = key;
    op.nstat = nstat;
    pending_ops.push_back(op);
    if (kind == skt_pkg::KIND_INSERT) key_pool.push_back(key);
  endtask

  // driver: one transfer per accepted item, prediction taken at the transfer
  always @(posedge clk) begin : drive_in
    table_op_t op;
    int n;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_kind       <= skt_pkg::KIND_LOOKUP;
      in_key        <= 32'd0;
      in_new_status <= skt_pkg::STATUS_AVAILABLE;
      gap_left      <= 0;
    end else if (in_valid && !in_stall) begin
      awaited_results.push_back(table_step(in_kind, in_key, in_new_status));
      items_sent++;
      n = calm ? 0 : idle_len();
      if (n == 0 && pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_kind       <= op.kind;
        in_key        <= op.key;
        in_new_status <= op.nstat;
      end else begin
        in_valid <= 1'b0;
        gap_left <= n;
      end
    end else if (!in_valid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_valid      <= 1'b1;
        in_kind       <= op.kind;
        in_key        <= op.key;
        in_new_status <= op.nstat;
      end
    end
  end

  // one long receiver hold-off, started once enough results have come
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall runs
  always @(posedge clk) begin : drive_stall
    int n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = calm ? 0 : idle_len();
      out_stall  <= hold_active || (n != 0);
      stall_left <= (n != 0) ? n - 1 : 0;
    end
  end

  // monitor: compare every output transfer with the oldest prediction
  always @(posedge clk) begin : check_out
    table_result_t er;
    logic bad;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_result_code <= skt_pkg::RC_FULL) code_seen[out_result_code]++;
      if (int'(out_entry_count) > max_entries) max_entries = out_entry_count;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d with no prediction pending: code=%0d cnt=%0d",
                   results_seen, out_result_code, out_entry_count);
      end else begin
        er  = awaited_results.pop_front();
        bad = (out_result_code  !== er.code)         ||
              (out_found        !== er.found)        ||
              (out_position     !== er.position)     ||
              (out_entry_status !== er.entry_status) ||
              (out_table_full   !== er.table_full)   ||
              (out_entry_count  !== er.entry_count);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d exp code=%0d found=%0b pos=%0d st=%0d full=%0b cnt=%0d",
                     results_seen, er.code, er.found, er.position, er.entry_status,
                     er.table_full, er.entry_count);
            $display("       got code=%0d found=%0b pos=%0d st=%0d full=%0b cnt=%0d",
                     out_result_code, out_found, out_position, out_entry_status,
                     out_table_full, out_entry_count);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    int r;
    logic [1:0] kind;
    for (i = 0; i < 5; i++) code_seen[i] = 0;

    // directed: empty table, extremes, every operation and every refusal but full
    push_op(skt_pkg::KIND_LOOKUP,   32'h0000_0000, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_REMOVE,   32'h0000_0005, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_RESERVED, 32'h0000_0007, 2'd3);
    push_op(skt_pkg::KIND_INSERT,   32'h8000_0000, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_INSERT,   32'h0000_0000, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_INSERT,   32'hFFFF_FFFF, 2'd2);
    push_op(skt_pkg::KIND_INSERT,   32'h4000_0000, skt_pkg::STATUS_DELETED);
    push_op(skt_pkg::KIND_INSERT,   32'h7FFF_FFFF, 2'd3);
    push_op(skt_pkg::KIND_INSERT,   32'h0000_0000, 2'd3);
    push_op(skt_pkg::KIND_LOOKUP,   32'h0000_0000, skt_pkg::STATUS_DELETED);
    push_op(skt_pkg::KIND_LOOKUP,   32'hFFFF_FFFF, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_LOOKUP,   32'h8000_0001, 2'd2);
    push_op(skt_pkg::KIND_REMOVE,   32'h0000_0000, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_REMOVE,   32'h0000_0000, 2'd3);
    push_op(skt_pkg::KIND_REMOVE,   32'hFFFF_FFFF, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_REMOVE,   32'h4000_0000, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_REMOVE,   32'h8000_0000, skt_pkg::STATUS_DELETED);
    push_op(skt_pkg::KIND_LOOKUP,   32'h0000_0001, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_RESERVED, 32'h7FFF_FFFF, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_INSERT,   32'h0000_0001, skt_pkg::STATUS_AVAILABLE);
    push_op(skt_pkg::KIND_INSERT,   32'hFFFF_FFFE, skt_pkg::STATUS_DELETED);

    // random: first half grows the table slowly, second half fills it
    for (i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (i < RANDOM_OPS / 2)
        kind = (r < 35) ? skt_pkg::KIND_LOOKUP : (r < 55) ? skt_pkg::KIND_INSERT :
               (r < 93) ? skt_pkg::KIND_REMOVE : skt_pkg::KIND_RESERVED;
      else
        kind = (r < 30) ? skt_pkg::KIND_LOOKUP : (r < 65) ? skt_pkg::KIND_INSERT :
               (r < 94) ? skt_pkg::KIND_REMOVE : skt_pkg::KIND_RESERVED;
      push_op(kind, pick_key(), 2'($urandom_range(0, 3)));
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Ran %0d table operations, %0d results: ok=%0d dup=%0d miss=%0d",
             items_sent, results_seen, code_seen[skt_pkg::RC_OK],
             code_seen[skt_pkg::RC_DUPLICATE], code_seen[skt_pkg::RC_NOT_FOUND]);
    $display("unavail=%0d full=%0d; table peaked at %0d of %0d entries; %0d mismatches",
             code_seen[skt_pkg::RC_NOT_AVAIL], code_seen[skt_pkg::RC_FULL],
             max_entries, TBL_DEPTH, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_sorted_key_table: PASS");
    end else begin
      $display("tb_sorted_key_table: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout: %0d results outstanding", awaited_results.size());
    $display("tb_sorted_key_table: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/sorted_key_table.sv
tb/tb_sorted_key_table.sv
